### rtl/forest_leaf_select_vote_assert.svh
// Assertion macros for the forest vote block checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FOREST_LEAF_SELECT_VOTE_ASSERT_SVH
`define FOREST_LEAF_SELECT_VOTE_ASSERT_SVH

// same-cycle implication
`define FLSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FLSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/flsv_pkg.sv
// Shared constants, types and helper functions for the forest vote block.
// No dependencies.
package flsv_pkg;

  localparam int MAX_DEPTH   = 4;
  localparam int MAX_TREES   = 128;
  localparam int LABEL_BITS  = 16;

  localparam int LEAVES      = 1 << MAX_DEPTH;
  localparam int STORE_DEPTH = MAX_TREES * LEAVES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // fixed item field widths
  localparam int TREE_W      = 7;
  localparam int LEAF_W      = 4;
  localparam int WORD_W      = 16;
  localparam int NODES_W     = 15;
  localparam int DEPTH_W     = 3;
  localparam int LCOUNT_W    = 5;
  localparam int VOTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int OH_W        = 16;

  localparam int NODE_W      = MAX_DEPTH + 1;
  localparam int DEPTH_CW    = $clog2(MAX_DEPTH + 1);
  localparam int LBL_W       = (LABEL_BITS > 1) ? $clog2(LABEL_BITS) : 1;
  localparam int NLAB_W      = $clog2(LABEL_BITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TREE_DEPTH  = 1'b0,
    CFG_LABEL_COUNT = 1'b1
  } cfg_reg_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // one queued item between front and back
  typedef struct packed {
    logic              is_load;
    logic              vote_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              final_tree;
  } flsv_entry_t;

  function automatic logic [DEPTH_CW-1:0] eff_depth(input logic [DEPTH_W-1:0] v);
    logic [DEPTH_CW-1:0] r;
    if (v == '0) r = DEPTH_CW'(1);
    else if (32'(v) > MAX_DEPTH) r = DEPTH_CW'(MAX_DEPTH);
    else r = DEPTH_CW'(v);
    return r;
  endfunction

  function automatic logic [NLAB_W-1:0] eff_labels(input logic [LCOUNT_W-1:0] v);
    logic [NLAB_W-1:0] r;
    if (v == '0) r = NLAB_W'(1);
    else if (32'(v) > LABEL_BITS) r = NLAB_W'(LABEL_BITS);
    else r = NLAB_W'(v);
    return r;
  endfunction

endpackage

### rtl/forest_leaf_select_vote.sv
// Forest vote top level: configuration registers, front end, queue and back end.
// Depends on flsv_pkg, flsv_front, flsv_queue, flsv_back.
//
// Items enter through a two-entry queue, one per cycle while it has room. The
// back end takes a load item with one write to the leaf label store.
// An evaluate item takes a store read, then the counter update.
// An evaluate item marked as the last tree then scans the vote counters one
// label a cycle, and its result enters the output register once that register
// is empty. The store needs no clearing after reset; its entries must be
// loaded before a tree that reaches them is evaluated. Configuration is applied
// at once and must only be written while no item is in flight.
module forest_leaf_select_vote import flsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_mode,
  input  logic [TREE_W-1:0]    in_tree_index,
  input  logic [LEAF_W-1:0]    in_leaf_index,
  input  logic [WORD_W-1:0]    in_label_word,
  input  logic [NODES_W-1:0]   in_node_bits,
  input  logic                 in_final_tree,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [OH_W-1:0]      out_winner_onehot,
  output logic [IDX_W-1:0]     out_winner_index,
  output logic [VOTE_W-1:0]    out_winner_votes,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LCOUNT_W-1:0]  cfg_wdata
);

  logic [DEPTH_W-1:0]  tree_depth_r;
  logic [LCOUNT_W-1:0] label_count_r;
  logic [DEPTH_CW-1:0] depth;
  logic [NLAB_W-1:0]   nlab;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  flsv_entry_t q_in;
  flsv_entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_depth_r  <= DEPTH_W'(4);
      label_count_r <= LCOUNT_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TREE_DEPTH:  tree_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        CFG_LABEL_COUNT: label_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign depth = eff_depth(tree_depth_r);
  assign nlab  = eff_labels(label_count_r);

  flsv_front u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_tree_index (in_tree_index),
    .in_leaf_index (in_leaf_index),
    .in_label_word (in_label_word),
    .in_node_bits  (in_node_bits),
    .in_final_tree (in_final_tree),
    .depth         (depth),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  flsv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  flsv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .nlab              (nlab),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_winner_onehot (out_winner_onehot),
    .out_winner_index  (out_winner_index),
    .out_winner_votes  (out_winner_votes)
  );

endmodule

### rtl/flsv_front.sv
// Front end: takes items, walks the tree for evaluate items, builds queue entries.
// Depends on flsv_pkg.
module flsv_front import flsv_pkg::*; (
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_mode,
  input  logic [TREE_W-1:0]   in_tree_index,
  input  logic [LEAF_W-1:0]   in_leaf_index,
  input  logic [WORD_W-1:0]   in_label_word,
  input  logic [NODES_W-1:0]  in_node_bits,
  input  logic                in_final_tree,
  input  logic [DEPTH_CW-1:0] depth,
  input  logic                q_full,
  output logic                q_push,
  output flsv_entry_t         q_entry
);

  logic [NODE_W-1:0] walk_node;
  logic [NODE_W-1:0] leaf_num;
  logic              tree_ok;
  logic              accept;

  // breadth-first walk, one level per step
  always_comb begin
    walk_node = '0;
    for (int d = 0; d < MAX_DEPTH; d++) begin
      if (d < int'(depth)) begin
        walk_node = {walk_node[NODE_W-2:0], 1'b0} + NODE_W'(1)
                    + NODE_W'(in_node_bits[walk_node[NODE_W-2:0]]);
      end
    end
  end

  assign leaf_num = walk_node + NODE_W'(1) - (NODE_W'(1) << depth);
  assign tree_ok  = 32'(in_tree_index) < MAX_TREES;
  assign accept   = in_push && !q_full;
  assign in_full  = q_full;

  // loads to a tree outside the store are dropped at the door
  assign q_push = accept && ((in_mode == MODE_EVAL) || tree_ok);

  always_comb begin
    q_entry.is_load    = (in_mode == MODE_LOAD);
    q_entry.vote_en    = tree_ok;
    q_entry.word       = in_label_word;
    q_entry.final_tree = in_final_tree;
    if (in_mode == MODE_LOAD) begin
      q_entry.addr = (ADDR_W'(in_tree_index) << MAX_DEPTH) | ADDR_W'(in_leaf_index);
    end else begin
      q_entry.addr = (ADDR_W'(in_tree_index) << MAX_DEPTH) | ADDR_W'(leaf_num);
    end
  end

endmodule

### rtl/flsv_queue.sv
// Short item queue between the front and back ends.
// Depends on flsv_pkg.
module flsv_queue import flsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  flsv_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output flsv_entry_t head,
  output logic        empty
);

  flsv_entry_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + QPTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_entry;
        wr_ptr_r         <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

### rtl/flsv_back.sv
// Back end: leaf label store, saturating vote counters, argmax scan, result register.
// Depends on flsv_pkg.
module flsv_back import flsv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  flsv_entry_t       q_head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [NLAB_W-1:0] nlab,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [OH_W-1:0]   out_winner_onehot,
  output logic [IDX_W-1:0]  out_winner_index,
  output logic [VOTE_W-1:0] out_winner_votes
);

  typedef enum logic [1:0] {B_IDLE, B_VOTE, B_SCAN, B_EMIT} bstate_t;

  logic [WORD_W-1:0]     leaf_mem [STORE_DEPTH];
  logic [WORD_W-1:0]     rdata_r;

  bstate_t               state_r;
  logic [VOTE_W-1:0]     cnt_r [LABEL_BITS];
  logic                  vote_en_r;
  logic                  final_r;
  logic [LBL_W-1:0]      scan_idx_r;
  logic [LBL_W-1:0]      best_idx_r;
  logic [VOTE_W-1:0]     best_votes_r;
  logic                  out_valid_r;
  logic [OH_W-1:0]       onehot_r;
  logic [IDX_W-1:0]      index_r;
  logic [VOTE_W-1:0]     votes_r;
  logic [LABEL_BITS-1:0] vote_bits;
  logic [VOTE_W-1:0]     scan_cnt;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign vote_bits = LABEL_BITS'(rdata_r);
  assign scan_cnt  = cnt_r[scan_idx_r];

  assign out_empty         = !out_valid_r;
  assign out_winner_onehot = onehot_r;
  assign out_winner_index  = index_r;
  assign out_winner_votes  = votes_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_load) leaf_mem[q_head.addr] <= q_head.word;
    rdata_r <= leaf_mem[q_head.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int j = 0; j < LABEL_BITS; j++) cnt_r[j] <= '0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty && !q_head.is_load) begin
            vote_en_r <= q_head.vote_en;
            final_r   <= q_head.final_tree;
            state_r   <= B_VOTE;
          end
        end
        B_VOTE: begin
          // leaf vector read last cycle is now in rdata_r
          for (int j = 0; j < LABEL_BITS; j++) begin
            if (vote_en_r && vote_bits[j] && (j < int'(nlab)) && (cnt_r[j] != VOTE_MAX)) begin
              cnt_r[j] <= cnt_r[j] + VOTE_W'(1);
            end
          end
          if (final_r) begin
            scan_idx_r   <= '0;
            best_idx_r   <= '0;
            best_votes_r <= '0;
            state_r      <= B_SCAN;
          end else begin
            state_r <= B_IDLE;
          end
        end
        B_SCAN: begin
          // strict compare keeps the lowest index on ties
          if (scan_cnt > best_votes_r) begin
            best_idx_r   <= scan_idx_r;
            best_votes_r <= scan_cnt;
          end
          if (NLAB_W'(scan_idx_r) == nlab - NLAB_W'(1)) state_r <= B_EMIT;
          else scan_idx_r <= scan_idx_r + LBL_W'(1);
        end
        B_EMIT: begin
          if (!out_valid_r) begin
            onehot_r    <= OH_W'(1) << best_idx_r;
            index_r     <= IDX_W'(best_idx_r);
            votes_r     <= best_votes_r;
            out_valid_r <= 1'b1;
            for (int j = 0; j < LABEL_BITS; j++) cnt_r[j] <= '0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/flsv_checker.sv
// Port-level checks on the forest vote block, bound to its top level.
// Depends on flsv_pkg and forest_leaf_select_vote_assert.svh.
`include "forest_leaf_select_vote_assert.svh"

module flsv_checker import flsv_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [OH_W-1:0]   out_winner_onehot,
  input logic [IDX_W-1:0]  out_winner_index,
  input logic [VOTE_W-1:0] out_winner_votes
);

  // a waiting result holds until taken
  `FLSV_ASSERT_NXT(a_result_hold, !out_empty && !out_pop, !out_empty && $stable(out_winner_index) && $stable(out_winner_votes))

  `FLSV_ASSERT_IMP(a_onehot_match, !out_empty, out_winner_onehot == (OH_W'(1) << out_winner_index))

  // single result register: a taken item leaves a gap
  `FLSV_ASSERT_NXT(a_pop_gap, !out_empty && out_pop, out_empty)

  // with no votes at all, label zero wins
  `FLSV_ASSERT_IMP(a_zero_votes, !out_empty && (out_winner_votes == '0), out_winner_index == '0)

endmodule

bind forest_leaf_select_vote flsv_checker u_flsv_checker (.*);

### test/tb_forest_leaf_select_vote.sv
// Testbench for forest_leaf_select_vote: directed table with fixed expected
// winners, then random votes under several depth and label count settings, checked by a local predictor.
// Depends on flsv_pkg and forest_leaf_select_vote.
`timescale 1ns / 100ps

module tb_forest_leaf_select_vote;
  import flsv_pkg::*;

  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 20;
  localparam int SAT_EVALS      = 270;
  localparam int SETTLE_CYCLES  = 2 + LABEL_BITS + 1 + 4 * QUEUE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic               mode;
    logic [TREE_W-1:0]  tree;
    logic [LEAF_W-1:0]  leaf;
    logic [WORD_W-1:0]  word;
    logic [NODES_W-1:0] nodes;
    logic               final_tree;
  } vote_item_t;

  typedef struct packed {
    logic [OH_W-1:0]   onehot;
    logic [IDX_W-1:0]  idx;
    logic [VOTE_W-1:0] votes;
  } winner_t;

  typedef struct packed {
    vote_item_t it;
    bit         typed;
    winner_t    want;
  } stim_row_t;

  localparam int N_DIRECTED = 14;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // nothing voted yet: label 0 wins with no votes
    '{'{MODE_LOAD, 7'd0,   4'd0,  16'h0000, 15'h0000, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd0,   4'd0,  16'h0000, 15'h0000, 1'b1}, 1'b1, '{16'h0001, 4'd0,  8'd0}},
    // all labels tie on one vote, lowest index wins
    '{'{MODE_LOAD, 7'd127, 4'd15, 16'hFFFF, 15'h0000, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd127, 4'd15, 16'h0000, 15'h7FFF, 1'b1}, 1'b1, '{16'h0001, 4'd0,  8'd1}},
    // final mark on a load is ignored
    '{'{MODE_LOAD, 7'd127, 4'd15, 16'h8000, 15'h7FFF, 1'b1}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd127, 4'd0,  16'hFFFF, 15'h7FFF, 1'b1}, 1'b1, '{16'h8000, 4'd15, 8'd1}},
    // labels 5 and 10 tie on two votes
    '{'{MODE_LOAD, 7'd64,  4'd5,  16'h0420, 15'h0000, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd64,  4'd0,  16'h0000, 15'h0202, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd64,  4'd0,  16'h0000, 15'h0202, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd0,   4'd0,  16'h0000, 15'h0000, 1'b1}, 1'b1, '{16'h0020, 4'd5,  8'd2}},
    // off-path node bits must not steer the walk
    '{'{MODE_LOAD, 7'd85,  4'd10, 16'h5A5A, 15'h0000, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_LOAD, 7'd42,  4'd5,  16'hA5A5, 15'h0000, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd85,  4'd0,  16'h0000, 15'h6E7B, 1'b0}, 1'b0, '{16'h0000, 4'd0,  8'd0}},
    '{'{MODE_EVAL, 7'd42,  4'd0,  16'h0000, 15'h420A, 1'b1}, 1'b0, '{16'h0000, 4'd0,  8'd0}}
  };

  localparam int DEPTH_SET [8] = '{1, 0, 7, 2, 3, 4, 1, 5};
  localparam int COUNT_SET [8] = '{1, 0, 31, 5, 17, 16, 2, 9};

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_push       = 1'b0;
  logic                 in_full;
  logic                 in_mode       = MODE_LOAD;
  logic [TREE_W-1:0]    in_tree_index = '0;
  logic [LEAF_W-1:0]    in_leaf_index = '0;
  logic [WORD_W-1:0]    in_label_word = '0;
  logic [NODES_W-1:0]   in_node_bits  = '0;
  logic                 in_final_tree = 1'b0;
  logic                 out_empty;
  logic                 out_pop       = 1'b0;
  logic [OH_W-1:0]      out_winner_onehot;
  logic [IDX_W-1:0]     out_winner_index;
  logic [VOTE_W-1:0]    out_winner_votes;
  logic                 cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_TREE_DEPTH;
  logic [LCOUNT_W-1:0]  cfg_wdata     = '0;

  // predictor state
  logic [WORD_W-1:0]  leaf_words  [STORE_DEPTH];
  bit                 leaf_loaded [STORE_DEPTH];
  logic [VOTE_W-1:0]  tally       [LABEL_BITS];
  logic [DEPTH_W-1:0] depth_reg;
  logic [LCOUNT_W-1:0] nlab_reg;

  winner_t winners_due[$];
  winner_t head;
  int      n_items;
  int      n_bad;
  int      burst_left;
  int      quiet;
  int      stall_style;
  int      stall_left;

  forest_leaf_select_vote i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_mode           (in_mode),
    .in_tree_index     (in_tree_index),
    .in_leaf_index     (in_leaf_index),
    .in_label_word     (in_label_word),
    .in_node_bits      (in_node_bits),
    .in_final_tree     (in_final_tree),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_winner_onehot (out_winner_onehot),
    .out_winner_index  (out_winner_index),
    .out_winner_votes  (out_winner_votes),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int used_depth();
    int d;
    d = int'(depth_reg);
    if (d < 1) d = 1;
    else if (d > MAX_DEPTH) d = MAX_DEPTH;
    return d;
  endfunction

  function automatic int used_labels();
    int n;
    n = int'(nlab_reg);
    if (n < 1) n = 1;
    else if (n > LABEL_BITS) n = LABEL_BITS;
    return n;
  endfunction

  // walk from the root: bit 0 goes to 2k+1, bit 1 to 2k+2
  function automatic int leaf_reached(input logic [NODES_W-1:0] nodes);
    int node;
    int depth;
    node = 0;
    depth = used_depth();
    for (int d = 0; d < depth; d++) node = 2 * node + 1 + int'(nodes[node]);
    return node + 1 - (1 << depth);
  endfunction

  // applies one item to the predictor; returns 1 when it yields a winner
  function automatic bit tally_item(input vote_item_t it, output winner_t w);
    int addr;
    int nlab;
    int best;
    logic [WORD_W-1:0] vec;
    w = '0;
    if (it.mode == MODE_LOAD) begin
      addr = int'(it.tree) * LEAVES + int'(it.leaf);
      leaf_words[addr] = it.word;
      leaf_loaded[addr] = 1'b1;
      return 1'b0;
    end
    nlab = used_labels();
    if (int'(it.tree) < MAX_TREES) begin
      vec = leaf_words[int'(it.tree) * LEAVES + leaf_reached(it.nodes)];
      for (int j = 0; j < nlab; j++)
        if (vec[j] && tally[j] != VOTE_MAX) tally[j] = tally[j] + VOTE_W'(1);
    end
    if (!it.final_tree) return 1'b0;
    best = 0;
    for (int j = 1; j < nlab; j++)
      if (tally[j] > tally[best]) best = j;
    w.onehot = OH_W'(1) << best;
    w.idx    = IDX_W'(best);
    w.votes  = tally[best];
    for (int j = 0; j < LABEL_BITS; j++) tally[j] = '0;
    return 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      default: v = WORD_W'($urandom);
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input vote_item_t it, input bit typed, input winner_t want);
    winner_t w;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_push       <= 1'b1;
    in_mode       <= it.mode;
    in_tree_index <= it.tree;
    in_leaf_index <= it.leaf;
    in_label_word <= it.word;
    in_node_bits  <= it.nodes;
    in_final_tree <= it.final_tree;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    n_items++;
    if (tally_item(it, w)) winners_due.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    burst_left = 0;
    while (winners_due.size() != 0) @(negedge clk);
    // non-final items may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input int depth, input int labels);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TREE_DEPTH;
    cfg_wdata <= LCOUNT_W'(depth);
    @(negedge clk);
    cfg_index <= CFG_LABEL_COUNT;
    cfg_wdata <= LCOUNT_W'(labels);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    depth_reg = DEPTH_W'(depth);
    nlab_reg  = LCOUNT_W'(labels);
  endtask

  // one vote: a run of tree evaluations, the last one marked final, with
  // loads ahead of any leaf not yet written and some stray loads between
  task automatic cast_vote(input int n_trees, input bit hot);
    vote_item_t it;
    vote_item_t ld;
    int leaf;
    for (int t = 0; t < n_trees; t++) begin
      if ($urandom_range(0, 5) == 0) begin
        ld.mode       = MODE_LOAD;
        ld.tree       = TREE_W'($urandom);
        ld.leaf       = LEAF_W'($urandom);
        ld.word       = pick_word();
        ld.nodes      = NODES_W'($urandom);
        ld.final_tree = 1'($urandom);
        send(ld, 1'b0, '0);
      end
      it.mode       = MODE_EVAL;
      it.tree       = hot ? TREE_W'($urandom_range(0, 3)) : TREE_W'($urandom);
      it.leaf       = LEAF_W'($urandom);
      it.word       = WORD_W'($urandom);
      it.nodes      = NODES_W'($urandom);
      it.final_tree = (t == n_trees - 1);
      leaf = leaf_reached(it.nodes);
      if (!leaf_loaded[int'(it.tree) * LEAVES + leaf]) begin
        ld.mode       = MODE_LOAD;
        ld.tree       = it.tree;
        ld.leaf       = LEAF_W'(leaf);
        ld.word       = pick_word();
        ld.nodes      = NODES_W'($urandom);
        ld.final_tree = 1'($urandom);
        send(ld, 1'b0, '0);
      end
      send(it, 1'b0, '0);
    end
  endtask

  // result side: stall style changes every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_style)
      2: out_pop <= 1'($urandom_range(0, 1));
      3: out_pop <= ($urandom_range(0, 9) == 0);
      default: out_pop <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (winners_due.size() == 0) begin
        $display("%0t: unexpected result index %0d votes %0d", $time,
                 out_winner_index, out_winner_votes);
        n_bad++;
      end else begin
        head = winners_due.pop_front();
        if (out_winner_onehot !== head.onehot) begin
          $display("%0t: winner_onehot expected %h actual %h", $time,
                   head.onehot, out_winner_onehot);
          n_bad++;
        end
        if (out_winner_index !== head.idx) begin
          $display("%0t: winner_index expected %0d actual %0d", $time,
                   head.idx, out_winner_index);
          n_bad++;
        end
        if (out_winner_votes !== head.votes) begin
          $display("%0t: winner_votes expected %0d actual %0d", $time,
                   head.votes, out_winner_votes);
          n_bad++;
        end
      end
    end
  end

  // no item moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("forest_leaf_select_vote: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int quota;
    vote_item_t it;
    n_items     = 0;
    n_bad       = 0;
    burst_left  = 0;
    quiet       = 0;
    stall_style = 0;
    stall_left  = 0;
    depth_reg   = DEPTH_W'(4);
    nlab_reg    = LCOUNT_W'(16);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      leaf_words[i]  = '0;
      leaf_loaded[i] = 1'b0;
    end
    for (int j = 0; j < LABEL_BITS; j++) tally[j] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < N_DIRECTED; k++)
      send(DIRECTED[k].it, DIRECTED[k].typed, DIRECTED[k].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph < 8) write_cfg(DEPTH_SET[ph], COUNT_SET[ph]);
      else write_cfg($urandom_range(0, 7), $urandom_range(0, 31));
      quota = n_items + PHASE_ITEMS;
      while (n_items < quota)
        cast_vote(($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6),
                  1'($urandom));
    end

    // one long vote on a single tree so that counters saturate
    settle();
    write_cfg(4, 16);
    for (int l = 0; l < LEAVES; l++) begin
      it.mode       = MODE_LOAD;
      it.tree       = TREE_W'(100);
      it.leaf       = LEAF_W'(l);
      it.word       = WORD_W'($urandom) | 16'h0C00;
      it.nodes      = '0;
      it.final_tree = 1'b0;
      send(it, 1'b0, '0);
    end
    for (int e = 0; e < SAT_EVALS; e++) begin
      it.mode       = MODE_EVAL;
      it.tree       = TREE_W'(100);
      it.leaf       = LEAF_W'($urandom);
      it.word       = WORD_W'($urandom);
      it.nodes      = NODES_W'($urandom);
      it.final_tree = (e == SAT_EVALS - 1);
      send(it, 1'b0, '0);
    end

    settle();
    if (n_bad == 0) begin
      $display("forest_leaf_select_vote: match");
    end else begin
      $display("forest_leaf_select_vote: mismatch");
    end
    $finish;
  end

endmodule
